[rtl/slpr_pkg.sv]
package slpr_pkg;

  // Field and register widths
  localparam int unsigned ClockHzW    = 27;
  localparam int unsigned SampleRateW = 18;
  localparam int unsigned VolumeW     = 10;
  localparam int unsigned SwingW      = 15;
  localparam int unsigned LevelW      = 16;
  localparam int unsigned CountW      = 28;
  localparam int unsigned CfgAddrW    = 2;

  // Reset values of the configuration registers
  localparam logic [ClockHzW-1:0]    ClockHzReset    = 27'd1193182;
  localparam logic [SampleRateW-1:0] SampleRateReset = 18'd44100;
  localparam logic [VolumeW-1:0]     VolumeMax       = 10'd1000;
  // 500 * 32767 / 1000, rounded down
  localparam logic [SwingW-1:0]      SwingReset      = 15'd16383;

  // Scaled reciprocal: floor(v * 32767 / 1000) == (v * SwingMul) >> SwingShift
  // holds exactly for every volume up to 1000.
  localparam int unsigned            SwingShift      = 20;
  localparam logic [25:0]            SwingMul        = 26'd34358690;

  localparam logic [LevelW-1:0] Midpoint = 16'h8000;
  localparam logic [CountW-1:0] CountMax = 28'h0FFFFFFF;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    REG_CLOCK_HZ    = 2'd0,
    REG_SAMPLE_RATE = 2'd1,
    REG_VOLUME      = 2'd2
  } cfg_reg_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_START  = 2'd1,
    KIND_STOP   = 2'd2
  } event_kind_t;

  // Current configuration as seen by the datapath
  typedef struct packed {
    logic [ClockHzW-1:0]    clock_hz;
    logic [SampleRateW-1:0] sample_rate;
    logic [SwingW-1:0]      swing;
  } cfg_t;

  // Result of one item, before the output register
  typedef struct packed {
    logic                valid;
    event_kind_t         kind;
    logic [LevelW-1:0]   word;
  } result_t;

endpackage

[rtl/slpr_cfg.sv]
module slpr_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [slpr_pkg::CfgAddrW-1:0]     cfg_addr,
  input  logic [slpr_pkg::ClockHzW-1:0]     cfg_wdata,
  output slpr_pkg::cfg_t                    cfg
);

  logic [slpr_pkg::ClockHzW-1:0]    clock_hz_r;
  logic [slpr_pkg::SampleRateW-1:0] sample_rate_r;
  logic [slpr_pkg::SwingW-1:0]      swing_r;

  logic [slpr_pkg::VolumeW-1:0]     vol_raw;
  logic [slpr_pkg::VolumeW-1:0]     vol_clamped;
  logic [35:0]                      swing_prod;
  logic [slpr_pkg::SwingW-1:0]      swing_nxt;

  // Clamp the volume and turn it into a swing once, at write time.
  always_comb begin
    vol_raw     = cfg_wdata[slpr_pkg::VolumeW-1:0];
    vol_clamped = (vol_raw > slpr_pkg::VolumeMax) ? slpr_pkg::VolumeMax : vol_raw;
    swing_prod  = 36'(vol_clamped) * 36'(slpr_pkg::SwingMul);
    swing_nxt   = swing_prod[slpr_pkg::SwingShift +: slpr_pkg::SwingW];
  end

  // Register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r    <= slpr_pkg::ClockHzReset;
      sample_rate_r <= slpr_pkg::SampleRateReset;
      swing_r       <= slpr_pkg::SwingReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        slpr_pkg::REG_CLOCK_HZ:    clock_hz_r    <= cfg_wdata;
        slpr_pkg::REG_SAMPLE_RATE: sample_rate_r <= cfg_wdata[slpr_pkg::SampleRateW-1:0];
        slpr_pkg::REG_VOLUME:      swing_r       <= swing_nxt;
        default: ;
      endcase
    end
  end

  assign cfg.clock_hz    = clock_hz_r;
  assign cfg.sample_rate = sample_rate_r;
  assign cfg.swing       = swing_r;

endmodule

[rtl/slpr_core.sv]
module slpr_core (
  input  logic              clk,
  input  logic              rst_n,
  input  slpr_pkg::cfg_t    cfg,
  input  logic              step,
  input  logic              gate,
  input  logic              data,
  input  logic              adv,
  output slpr_pkg::result_t res
);

  logic                          playing_r,  playing_nxt;
  logic [slpr_pkg::LevelW-1:0]   held_level_r, held_level_nxt;
  logic [slpr_pkg::CountW-1:0]   held_ticks_r, held_ticks_nxt;
  logic [slpr_pkg::LevelW-1:0]   acc_r, acc_nxt;
  logic [slpr_pkg::CountW-1:0]   phase_r, phase_nxt;

  logic [slpr_pkg::LevelW-1:0]   level;
  logic                          changed;
  logic [slpr_pkg::CountW-1:0]   ticks_inc;
  logic                          start;
  logic                          stop;
  logic                          tick;
  logic [21:0]                   filt_sum;
  logic [slpr_pkg::LevelW-1:0]   filt_val;
  logic [slpr_pkg::CountW:0]     phase_sum;
  logic [slpr_pkg::CountW-1:0]   phase_sat;
  logic                          emit;

  // Level from gate and data
  always_comb begin
    if (!gate) begin
      level = slpr_pkg::Midpoint;
    end else if (data) begin
      level = slpr_pkg::Midpoint + 16'(cfg.swing);
    end else begin
      level = slpr_pkg::Midpoint - 16'(cfg.swing);
    end
  end

  // Idle timer and start/stop decisions
  always_comb begin
    changed   = (held_level_r != level);
    ticks_inc = (held_ticks_r == slpr_pkg::CountMax) ? held_ticks_r
                                                     : held_ticks_r + 28'(adv);
    start = !playing_r && changed;
    stop  = playing_r && !changed && (ticks_inc > {cfg.clock_hz, 1'b0});
    tick  = playing_r && !stop && adv;
  end

  // One-pole lowpass: (63*acc + level) / 64
  always_comb begin
    filt_sum = {acc_r, 6'd0} - {6'd0, acc_r} + {6'd0, level};
    filt_val = filt_sum[21:6];
  end

  // Phase accumulator with saturation and one wrap per tick
  always_comb begin
    phase_sum = {1'b0, phase_r} + 29'(cfg.sample_rate);
    phase_sat = phase_sum[slpr_pkg::CountW] ? slpr_pkg::CountMax
                                            : phase_sum[slpr_pkg::CountW-1:0];
    emit      = (phase_sat >= 28'(cfg.clock_hz));
  end

  // Next state
  always_comb begin
    playing_nxt    = playing_r;
    held_level_nxt = held_level_r;
    held_ticks_nxt = held_ticks_r;
    acc_nxt        = acc_r;
    phase_nxt      = phase_r;
    if (start) begin
      playing_nxt    = 1'b1;
      held_level_nxt = slpr_pkg::Midpoint;
      held_ticks_nxt = '0;
      acc_nxt        = slpr_pkg::Midpoint;
      phase_nxt      = '0;
    end else if (playing_r) begin
      if (changed) begin
        held_level_nxt = level;
        held_ticks_nxt = 28'(adv);
      end else begin
        held_ticks_nxt = ticks_inc;
      end
      if (stop) begin
        playing_nxt = 1'b0;
      end
      if (tick) begin
        acc_nxt   = filt_val;
        phase_nxt = emit ? phase_sat - 28'(cfg.clock_hz) : phase_sat;
      end
    end
  end

  // Result of this item
  always_comb begin
    res.valid = start || stop || (tick && emit);
    res.word  = '0;
    if (start) begin
      res.kind = slpr_pkg::KIND_START;
    end else if (stop) begin
      res.kind = slpr_pkg::KIND_STOP;
    end else begin
      res.kind = slpr_pkg::KIND_SAMPLE;
      res.word = filt_val ^ slpr_pkg::Midpoint;
    end
  end

  // State registers, updated once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r    <= 1'b0;
      held_level_r <= slpr_pkg::Midpoint;
      held_ticks_r <= '0;
      acc_r        <= slpr_pkg::Midpoint;
      phase_r      <= '0;
    end else if (step) begin
      playing_r    <= playing_nxt;
      held_level_r <= held_level_nxt;
      held_ticks_r <= held_ticks_nxt;
      acc_r        <= acc_nxt;
      phase_r      <= phase_nxt;
    end
  end

  // A start leaves the block playing with a fresh filter.
  a_start_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (step && start) |=> (playing_r && acc_r == slpr_pkg::Midpoint && phase_r == '0))
    else $error("start did not reset the playback state");

  // A stop leaves the block idle.
  a_stop_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (step && stop) |=> !playing_r)
    else $error("stop did not end playback");

  // While idle, only a start changes the playing state.
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !playing_r && !start) |=> (!playing_r && $stable(acc_r)))
    else $error("idle state changed without a start");

endmodule

[rtl/speaker_level_to_pcm_resampler_top.sv]
// An accepted item waits in the input register, and its result goes to the output
// register as the item moves on. Throughput: one item per cycle unless a result waits
// on a full output; the filter, phase accumulator and idle timer are combinational
// between the two registers. While a result waits, an item without a result moves on,
// and one with a result holds the input until the output frees. Reset is synchronous
// and active low; it clears the handshake and playback state and restores the register defaults.
module speaker_level_to_pcm_resampler_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,  // [0] speaker_gate, [1] speaker_data, [2] advance
  // Result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata, // [15:0] sample_word
  output logic [1:0]                    out_tuser, // [1:0] event_kind
  // Configuration write port
  input  logic                          cfg_we,
  input  logic [slpr_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [slpr_pkg::ClockHzW-1:0] cfg_wdata
);

  slpr_pkg::cfg_t    cfg;
  slpr_pkg::result_t res;

  logic        in_vld_r;
  logic        gate_r, data_r, adv_r;
  logic        out_vld_r;
  logic [15:0] out_word_r;
  logic [1:0]  out_kind_r;
  logic        in_fire;
  logic        go;

  slpr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  slpr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (go),
    .gate  (gate_r),
    .data  (data_r),
    .adv   (adv_r),
    .res   (res)
  );

  // The held item moves on unless it has a result and the output is full.
  assign go        = in_vld_r && (!res.valid || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || go;
  assign in_fire   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_fire) begin
      in_vld_r <= 1'b1;
    end else if (go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      gate_r <= in_tdata[0];
      data_r <= in_tdata[1];
      adv_r  <= in_tdata[2];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (go && res.valid) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res.valid) begin
      out_word_r <= res.word;
      out_kind_r <= res.kind;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = out_kind_r;

endmodule

[dv/testbench.sv]
module testbench;

  // Register index that the block does not decode.
  localparam logic [slpr_pkg::CfgAddrW-1:0] RegNone = 2'd3;
  // Generous cycle budget for the whole run.
  localparam int unsigned RunLimit = 400000;

  typedef struct {
    slpr_pkg::event_kind_t       kind;
    logic [slpr_pkg::LevelW-1:0] word;
  } pcm_event_t;

  // Tracks the speaker state and the PCM events that the accepted items must cause.
  class speaker_pcm_model_t;
    logic [slpr_pkg::ClockHzW-1:0]    clock_hz;
    logic [slpr_pkg::SampleRateW-1:0] rate;
    logic [slpr_pkg::VolumeW-1:0]     volume;
    logic                             playing;
    logic [slpr_pkg::LevelW-1:0]      held_level;
    logic [slpr_pkg::CountW-1:0]      held_ticks;
    logic [slpr_pkg::LevelW-1:0]      acc;
    logic [slpr_pkg::CountW-1:0]      phase;
    pcm_event_t                       awaited_events[$];
    int                               fail_count;

    function new();
      clock_hz   = slpr_pkg::ClockHzReset;
      rate       = slpr_pkg::SampleRateReset;
      volume     = 10'd500;
      playing    = 1'b0;
      held_level = slpr_pkg::Midpoint;
      held_ticks = '0;
      acc        = slpr_pkg::Midpoint;
      phase      = '0;
      fail_count = 0;
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
    endtask

    // Register write; fields are masked to their width and volume clamps.
    function void write_reg(logic [slpr_pkg::CfgAddrW-1:0] idx,
                            logic [slpr_pkg::ClockHzW-1:0] val);
      case (idx)
        slpr_pkg::REG_CLOCK_HZ: begin
          clock_hz = val;
        end
        slpr_pkg::REG_SAMPLE_RATE: begin
          rate = val[slpr_pkg::SampleRateW-1:0];
        end
        slpr_pkg::REG_VOLUME: begin
          volume = (val[slpr_pkg::VolumeW-1:0] > slpr_pkg::VolumeMax) ?
                   slpr_pkg::VolumeMax : val[slpr_pkg::VolumeW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Advance the state by one accepted item and queue the event it causes.
    function void take_levels(logic [2:0] fields);
      logic                        gate, data, adv;
      logic [slpr_pkg::LevelW-1:0] swing, level;
      logic [31:0]                 sum;
      gate  = fields[0];
      data  = fields[1];
      adv   = fields[2];
      swing = slpr_pkg::LevelW'((32'(volume) * 32'd32767) / 32'd1000);
      if (!gate) level = slpr_pkg::Midpoint;
      else level = data ? slpr_pkg::Midpoint + swing : slpr_pkg::Midpoint - swing;

      // A stopped speaker only wakes up on a level change.
      if (!playing) begin
        if (held_level != level) begin
          playing    = 1'b1;
          held_level = slpr_pkg::Midpoint;
          held_ticks = '0;
          acc        = slpr_pkg::Midpoint;
          phase      = '0;
          awaited_events.push_back('{slpr_pkg::KIND_START, '0});
        end
        return;
      end

      // Idle timer: a level held too long ends playback.
      if (held_level == level) begin
        if (held_ticks != slpr_pkg::CountMax)
          held_ticks = held_ticks + slpr_pkg::CountW'(adv);
        if (held_ticks > {clock_hz, 1'b0}) begin
          playing = 1'b0;
          awaited_events.push_back('{slpr_pkg::KIND_STOP, '0});
          return;
        end
      end else begin
        held_level = level;
        held_ticks = slpr_pkg::CountW'(adv);
      end
      if (!adv) return;

      // One tick: lowpass, then the saturating phase accumulator.
      acc = slpr_pkg::LevelW'((32'd63 * 32'(acc) + 32'(level)) / 32'd64);
      sum = 32'(phase) + 32'(rate);
      if (sum > 32'(slpr_pkg::CountMax)) sum = 32'(slpr_pkg::CountMax);
      phase = sum[slpr_pkg::CountW-1:0];
      if (phase >= slpr_pkg::CountW'(clock_hz)) begin
        phase = phase - slpr_pkg::CountW'(clock_hz);
        awaited_events.push_back('{slpr_pkg::KIND_SAMPLE, acc ^ slpr_pkg::Midpoint});
      end
    endfunction

    // Compare one accepted result with the oldest awaited event.
    task match_event(logic [1:0] kind, logic [slpr_pkg::LevelW-1:0] word);
      pcm_event_t want;
      if (awaited_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind %0d word %h", kind, word));
        return;
      end
      want = awaited_events.pop_front();
      if (kind !== want.kind)
        flag_mismatch($sformatf("kind %0d, wanted %0d", kind, want.kind));
      if (word !== want.word)
        flag_mismatch($sformatf("word %h, wanted %h (kind %0d)", word, want.word, want.kind));
    endtask
  endclass

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [7:0]                    in_tdata   = 8'h00; // [0] speaker_gate, [1] speaker_data, [2] advance
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [15:0]                   out_tdata;          // [15:0] sample_word
  logic [1:0]                    out_tuser;          // [1:0] event_kind
  logic                          cfg_we     = 1'b0;
  logic [slpr_pkg::CfgAddrW-1:0] cfg_addr   = '0;
  logic [slpr_pkg::ClockHzW-1:0] cfg_wdata  = '0;

  int unsigned        send_idle_pct  = 0;
  int unsigned        recv_stall_pct = 0;
  logic               rx_hold        = 1'b0;
  speaker_pcm_model_t pcm_model      = new();

  speaker_level_to_pcm_resampler_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one item after an optional random gap and wait until it is taken.
  task offer_levels(logic [2:0] fields);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, fields};
    do @(posedge clk); while (in_tready !== 1'b1);
    pcm_model.take_levels(fields);
  endtask

  // Stop offering, let every awaited event arrive, then allow the pipeline to settle.
  task settle();
    in_tvalid <= 1'b0;
    while (pcm_model.awaited_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task load_register(logic [slpr_pkg::CfgAddrW-1:0] idx,
                     logic [slpr_pkg::ClockHzW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    pcm_model.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Write all three registers; bits above the rate and volume fields are random.
  task configure(int unsigned clock_hz, int unsigned rate, int unsigned vol);
    load_register(slpr_pkg::REG_CLOCK_HZ, slpr_pkg::ClockHzW'(clock_hz));
    load_register(slpr_pkg::REG_SAMPLE_RATE,
                  {9'($urandom), slpr_pkg::SampleRateW'(rate)});
    load_register(slpr_pkg::REG_VOLUME, {17'($urandom), slpr_pkg::VolumeW'(vol)});
  endtask

  // Runs of one held level with random ticks, mixed with fully random items.
  task run_levels(int count, int max_hold, int unsigned adv_pct);
    int         sent;
    int         hold;
    logic [1:0] lvl;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        offer_levels(3'($urandom));
        sent++;
      end else begin
        lvl  = 2'($urandom);
        hold = $urandom_range(max_hold, 1);
        for (int i = 0; i < hold && sent < count; i++) begin
          offer_levels({1'($urandom_range(99) < adv_pct), lvl});
          sent++;
        end
      end
    end
  endtask

  // Result side: check each accepted result, then choose the next ready value.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready)
        pcm_model.match_event(out_tuser, out_tdata);
      out_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(8 * RunLimit);
    $display("speaker_level_to_pcm_resampler_top verification failed");
    $finish;
  end

  initial begin
    logic [2:0]  opening_items[] = '{3'b100, 3'b010, 3'b011, 3'b111, 3'b101, 3'b000,
                                     3'b100, 3'b110};
    logic [2:0]  zero_clock_items[] = '{3'b111, 3'b111, 3'b111, 3'b001, 3'b101, 3'b101};
    logic [2:0]  silent_items[] = '{3'b111, 3'b111, 3'b000};
    int unsigned clock_hz;
    int          waited;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: idle midpoint, start on a level change, plain ticks.
    foreach (opening_items[i]) offer_levels(opening_items[i]);
    settle();

    // Zero clock with the largest rate: a sample on every tick and an early stop.
    // Volume above the limit clamps, and the unused index is ignored.
    load_register(slpr_pkg::REG_CLOCK_HZ, '0);
    load_register(slpr_pkg::REG_SAMPLE_RATE, 27'h003FFFF);
    load_register(slpr_pkg::REG_VOLUME, 27'd1023);
    load_register(RegNone, 27'h5555555);
    foreach (zero_clock_items[i]) offer_levels(zero_clock_items[i]);
    settle();

    // Largest clock, zero rate and zero volume: every level is the midpoint.
    configure(32'h07FFFFFF, 0, 0);
    foreach (silent_items[i]) offer_levels(silent_items[i]);
    settle();

    // Short clocks so that samples, starts and stops all come often.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      clock_hz = $urandom_range(40, 8);
      configure(clock_hz, $urandom_range(clock_hz, 1), $urandom_range(1023, 1));
      run_levels(150, 3 * clock_hz, 80);
      settle();
    end

    // Receiver holds off for a long stretch while items keep coming.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(4, 4, 1000);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (200) @(posedge clk);
        rx_hold <= 1'b0;
      end
      run_levels(100, 12, 90);
    join
    settle();

    // Rate far above the clock: the phase climbs until it saturates.
    send_idle_pct  = 32;
    recv_stall_pct = 32;
    configure(1000, 32'h3FFFF, 1000);
    run_levels(1100, 40, 97);

    // Drain, then keep watching for stray results.
    in_tvalid <= 1'b0;
    waited = 0;
    while (pcm_model.awaited_events.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pcm_model.awaited_events.size() != 0)
      pcm_model.flag_mismatch($sformatf("%0d results never arrived",
                                        pcm_model.awaited_events.size()));
    repeat (10) @(posedge clk);
    if (pcm_model.fail_count == 0) begin
      $display("speaker_level_to_pcm_resampler_top verification clean");
    end else begin
      $display("speaker_level_to_pcm_resampler_top verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/slpr_pkg.sv
rtl/slpr_cfg.sv
rtl/slpr_core.sv
rtl/speaker_level_to_pcm_resampler_top.sv
dv/testbench.sv
